>>> rtl/set_assoc_cache_controller_core_macros.svh
// ----------------------------------------------------------------------------
// set-associative cache controller assertion macros
// shared helpers for concurrent checks on the controller core
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_CONTROLLER_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_CONTROLLER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SACC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SACC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define SACC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SACC_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> rtl/sacc_pkg.sv
// ----------------------------------------------------------------------------
// sacc_pkg
// types and constants of the set-associative cache controller
// ----------------------------------------------------------------------------
package sacc_pkg;

  localparam int WAYS       = 4;
  localparam int SETS       = 64;
  localparam int LINE_BYTES = 64;

  localparam int ADDR_W   = 64;
  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS = $clog2(SETS);
  localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int TAG_BITS = ADDR_W - OFF_BITS - SET_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LRU_W    = WAY_W;
  localparam int RES_WAY_W = 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_THROUGH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ALLOCATE = 1'b1;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [RES_WAY_W-1:0] way;
    logic                 writeback;
    logic [ADDR_W-1:0]    writeback_address;
    logic                 refill;
    logic                 write_lower;
  } res_t;

  typedef struct packed {
    logic capture;  // latch request, read the set
    logic commit;   // decide, update set state, register result
  } cmd_t;

  typedef struct packed {
    logic [WAYS-1:0][TAG_BITS-1:0] tag;
    logic [WAYS-1:0]               dirty;
    logic [WAYS-1:0][LRU_W-1:0]    lru;
  } row_t;

endpackage

>>> rtl/sacc_ctrl.sv
// ----------------------------------------------------------------------------
// sacc_ctrl
// sequencer: read the set, then decide and write the set back
// ----------------------------------------------------------------------------
module sacc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  output sacc_pkg::cmd_t  cmd_o
);

  sacc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sacc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    busy_o        = 1'b0;
    case (state_q)
      sacc_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sacc_pkg::ST_LOOKUP;
        end
      end
      sacc_pkg::ST_LOOKUP: begin
        busy_o       = 1'b1;
        cmd_o.commit = 1'b1;
        state_d      = sacc_pkg::ST_IDLE;
      end
      default: begin
        state_d = sacc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/sacc_dpath.sv
// ----------------------------------------------------------------------------
// sacc_dpath
// tag memory, valid bits, tag compare, victim choice and lru update
// ----------------------------------------------------------------------------
module sacc_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sacc_pkg::cmd_t                     cmd_i,
  input  sacc_pkg::req_t                     req_i,
  input  logic                               cfg_we_i,
  input  logic [sacc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sacc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  output logic                               done_o,
  output sacc_pkg::res_t                     res_o
);

  localparam int HI_BITS = sacc_pkg::OFF_BITS + sacc_pkg::SET_BITS;

  // configuration
  logic wt_q, wa_q;

  // request
  logic                          op_q;
  logic [sacc_pkg::TAG_BITS-1:0] tag_q;
  logic [sacc_pkg::SET_W-1:0]    set_q;

  // set state
  sacc_pkg::row_t            tag_mem [sacc_pkg::SETS];
  sacc_pkg::row_t            rd_row_q;
  logic [sacc_pkg::WAYS-1:0] valid_q [sacc_pkg::SETS];
  logic                      row_init_q [sacc_pkg::SETS];
  logic [sacc_pkg::WAYS-1:0] vrow_q;
  logic                      init_q;

  // result
  logic           done_q;
  sacc_pkg::res_t res_q;

  logic [sacc_pkg::SET_W-1:0]    set_field;
  logic [sacc_pkg::SET_W-1:0]    set_in;

  logic [sacc_pkg::WAYS-1:0][sacc_pkg::LRU_W-1:0] lru_eff;
  logic                          hit;
  logic [sacc_pkg::WAY_W-1:0]    hit_way;
  logic [sacc_pkg::WAY_W-1:0]    victim;
  logic                          found_inv;
  logic [sacc_pkg::LRU_W-1:0]    best;
  logic [sacc_pkg::WAY_W-1:0]    use_way;
  logic                          no_alloc;
  logic                          wb;
  logic [sacc_pkg::ADDR_W-1:0]   wb_addr;
  sacc_pkg::row_t                new_row;
  logic [sacc_pkg::WAYS-1:0]     new_valid;
  sacc_pkg::res_t                res_d;

  // set index, folded below SETS by one compare and subtract
  assign set_field = sacc_pkg::SET_W'((req_i.address >> sacc_pkg::OFF_BITS)
                     & ((64'd1 << sacc_pkg::SET_BITS) - 64'd1));
  assign set_in = ({1'b0, set_field} >= (sacc_pkg::SET_W + 1)'(sacc_pkg::SETS))
                  ? sacc_pkg::SET_W'({1'b0, set_field}
                                     - (sacc_pkg::SET_W + 1)'(sacc_pkg::SETS))
                  : set_field;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q <= 1'b0;
      wa_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sacc_pkg::CFG_WRITE_THROUGH:  wt_q <= cfg_wdata_i[0];
        sacc_pkg::CFG_WRITE_ALLOCATE: wa_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q     <= req_i.operation;
      tag_q    <= sacc_pkg::TAG_BITS'(req_i.address >> HI_BITS);
      set_q    <= set_in;
      rd_row_q <= tag_mem[set_in];
      vrow_q   <= valid_q[set_in];
      init_q   <= row_init_q[set_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !no_alloc) begin
      tag_mem[set_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < sacc_pkg::SETS; s++) begin
        valid_q[s]    <= '0;
        row_init_q[s] <= 1'b0;
      end
    end else if (cmd_i.commit && !no_alloc) begin
      valid_q[set_q]    <= new_valid;
      row_init_q[set_q] <= 1'b1;
    end
  end

  // lookup and policy
  always_comb begin
    for (int w = 0; w < sacc_pkg::WAYS; w++) begin
      lru_eff[w] = init_q ? rd_row_q.lru[w] : '0;
    end

    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < sacc_pkg::WAYS; w++) begin
      if (!hit && vrow_q[w] && (rd_row_q.tag[w] == tag_q)) begin
        hit     = 1'b1;
        hit_way = sacc_pkg::WAY_W'(w);
      end
    end

    // first invalid way, else first way with the smallest counter
    found_inv = 1'b0;
    victim    = '0;
    for (int w = 0; w < sacc_pkg::WAYS; w++) begin
      if (!found_inv && !vrow_q[w]) begin
        found_inv = 1'b1;
        victim    = sacc_pkg::WAY_W'(w);
      end
    end
    best = lru_eff[0];
    if (!found_inv) begin
      for (int w = 1; w < sacc_pkg::WAYS; w++) begin
        if (lru_eff[w] < best) begin
          best   = lru_eff[w];
          victim = sacc_pkg::WAY_W'(w);
        end
      end
    end

    no_alloc = !hit && op_q && !wa_q;
    use_way  = hit ? hit_way : victim;
    wb       = !hit && !no_alloc && vrow_q[victim] && rd_row_q.dirty[victim];
    wb_addr  = wb ? ((sacc_pkg::ADDR_W'(rd_row_q.tag[victim]) << HI_BITS)
                     | (sacc_pkg::ADDR_W'(set_q) << sacc_pkg::OFF_BITS))
                  : '0;

    new_row   = rd_row_q;
    new_valid = vrow_q;
    if (!hit) begin
      new_row.tag[use_way]   = tag_q;
      new_row.dirty[use_way] = 1'b0;
      new_valid[use_way]     = 1'b1;
    end
    if (op_q && !wt_q) begin
      new_row.dirty[use_way] = 1'b1;
    end
    for (int w = 0; w < sacc_pkg::WAYS; w++) begin
      if (sacc_pkg::WAY_W'(w) == use_way) begin
        new_row.lru[w] = sacc_pkg::LRU_W'(sacc_pkg::WAYS - 1);
      end else if (lru_eff[w] != '0) begin
        new_row.lru[w] = lru_eff[w] - sacc_pkg::LRU_W'(1);
      end else begin
        new_row.lru[w] = '0;
      end
    end

    res_d.hit               = hit;
    res_d.way               = no_alloc ? '0 : sacc_pkg::RES_WAY_W'(use_way);
    res_d.writeback         = wb;
    res_d.writeback_address = wb_addr;
    res_d.refill            = !hit && !no_alloc;
    res_d.write_lower       = no_alloc || (op_q && wt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/set_assoc_cache_controller_core.sv
// the result strobe follows an accepted start through the lookup state and the done register
// a new item is taken only in the idle state; each item reads the set, then writes it back
// done_o is high for exactly one cycle per item; the receiver cannot stall
// reset clears all valid bits and lru state at once; tags are undefined until filled
// configuration resets to write-back, write-allocate
// ----------------------------------------------------------------------------
// set_assoc_cache_controller_core
// tag and replacement controller of a set-associative cache with lru counters
// ----------------------------------------------------------------------------
`include "set_assoc_cache_controller_core_macros.svh"

module set_assoc_cache_controller_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  sacc_pkg::req_t                  req_i,
  output logic                            done_o,
  output sacc_pkg::res_t                  res_o,
  input  logic                            cfg_we_i,
  input  logic [sacc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sacc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  sacc_pkg::cmd_t cmd;

  sacc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  sacc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .res_o       (res_o)
  );

  // an accepted item occupies the lookup cycle, then its result follows
  `SACC_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o, busy_o && !done_o)
  `SACC_ASSERT_NXT(a_busy_done, clk_i, rst_ni, busy_o, done_o && !busy_o)
  // a hit never asks lower memory for a line or a write-back
  `SACC_ASSERT_IMP(a_hit_clean, clk_i, rst_ni, done_o && res_o.hit,
                   !res_o.writeback && !res_o.refill)
  // a write-back only comes with a refill
  `SACC_ASSERT_IMP(a_wb_refill, clk_i, rst_ni, done_o && res_o.writeback, res_o.refill)

endmodule

>>> test/sacc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sacc_checker
// watches the cache controller ports, keeps its own copy of the tag, dirty
// and lru state, predicts each lookup outcome and compares it with the result
// ----------------------------------------------------------------------------
module sacc_checker
  import sacc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  req_t                  req_i,
  input  logic                  done_i,
  input  res_t                  res_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  logic                line_valid [SETS][WAYS];
  logic                line_dirty [SETS][WAYS];
  logic [TAG_BITS-1:0] line_tag   [SETS][WAYS];
  logic [LRU_W-1:0]    lru_count  [SETS][WAYS];
  logic                wt_mode;
  logic                wa_mode;

  res_t lookup_q [$];
  res_t want;

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] exp_val);
    $display("mismatch at %0t ns: %s got %h exp %h", $time, what, got, exp_val);
    fail_count_o++;
  endtask

  // works out the lookup outcome and updates the shadow set state
  function automatic res_t predict_access(req_t r);
    int                  s;
    int                  way;
    logic [TAG_BITS-1:0] t;
    logic                is_write;
    logic                hit;
    logic                found;
    res_t                o;
    o        = '0;
    is_write = r.operation;
    s   = int'(((r.address >> OFF_BITS) & ((64'd1 << SET_BITS) - 64'd1)) % SETS);
    t   = TAG_BITS'(r.address >> (OFF_BITS + SET_BITS));
    hit = 1'b0;
    way = 0;
    for (int i = 0; i < WAYS; i++) begin
      if (!hit && line_valid[s][i] && line_tag[s][i] == t) begin
        hit = 1'b1;
        way = i;
      end
    end
    if (!hit && is_write && !wa_mode) begin
      // write goes around the cache, nothing changes
      o.write_lower = 1'b1;
    end else begin
      if (!hit) begin
        found = 1'b0;
        for (int i = 0; i < WAYS; i++) begin
          if (!found && !line_valid[s][i]) begin
            way   = i;
            found = 1'b1;
          end
        end
        // smallest counter wins, first way on a tie
        if (!found) begin
          for (int i = 1; i < WAYS; i++)
            if (lru_count[s][i] < lru_count[s][way]) way = i;
        end
        if (line_valid[s][way] && line_dirty[s][way]) begin
          o.writeback         = 1'b1;
          o.writeback_address = (ADDR_W'(line_tag[s][way]) << (OFF_BITS + SET_BITS))
                              | (ADDR_W'(s) << OFF_BITS);
        end
        o.refill          = 1'b1;
        line_valid[s][way] = 1'b1;
        line_tag[s][way]   = t;
        line_dirty[s][way] = 1'b0;
        lru_count[s][way]  = '0;
      end
      if (is_write) begin
        if (wt_mode) o.write_lower = 1'b1;
        else         line_dirty[s][way] = 1'b1;
      end
      for (int i = 0; i < WAYS; i++) begin
        if (i == way)                  lru_count[s][i] = LRU_W'(WAYS - 1);
        else if (lru_count[s][i] != 0) lru_count[s][i] = lru_count[s][i] - 1'b1;
      end
    end
    o.hit = hit;
    o.way = RES_WAY_W'(way);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_mode = 1'b0;
      wa_mode = 1'b1;
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_valid[s][w] = 1'b0;
          line_dirty[s][w] = 1'b0;
          line_tag[s][w]   = '0;
          lru_count[s][w]  = '0;
        end
      end
      lookup_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_WRITE_THROUGH)       wt_mode = cfg_wdata_i[0];
        else if (cfg_idx_i == CFG_WRITE_ALLOCATE) wa_mode = cfg_wdata_i[0];
      end
      if (done_i) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("result with no item pending", ADDR_W'(res_i), '0);
        end else begin
          want = lookup_q.pop_front();
          if (res_i.hit !== want.hit)
            report_mismatch("hit", ADDR_W'(res_i.hit), ADDR_W'(want.hit));
          if (res_i.way !== want.way)
            report_mismatch("way", ADDR_W'(res_i.way), ADDR_W'(want.way));
          if (res_i.writeback !== want.writeback)
            report_mismatch("writeback", ADDR_W'(res_i.writeback),
                            ADDR_W'(want.writeback));
          if (res_i.writeback_address !== want.writeback_address)
            report_mismatch("writeback_address", res_i.writeback_address,
                            want.writeback_address);
          if (res_i.refill !== want.refill)
            report_mismatch("refill", ADDR_W'(res_i.refill), ADDR_W'(want.refill));
          if (res_i.write_lower !== want.write_lower)
            report_mismatch("write_lower", ADDR_W'(res_i.write_lower),
                            ADDR_W'(want.write_lower));
        end
      end
      if (start_i && !busy_i) lookup_q.push_back(predict_access(req_i));
      pending_o = lookup_q.size();
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives reads and writes at the cache controller across the write-through
// and write-allocate modes, with hot sets and a small tag pool so that hits,
// evictions and dirty write-backs are frequent; the checker does the scoring
// ----------------------------------------------------------------------------
module tb_top;
  import sacc_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int RANDOM_PER_PHASE = 400;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  req_t                  req       = '0;
  logic                  done;
  res_t                  res;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_WRITE_THROUGH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending;

  logic [TAG_BITS-1:0] tag_pool [8];
  bit                  burst;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  set_assoc_cache_controller_core u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .start_i    (start),
    .busy_o     (busy),
    .req_i      (req),
    .done_o     (done),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  sacc_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req),
    .done_i      (done),
    .res_i       (res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_BITS-1:0] t, int s, int off);
    return {t, SET_BITS'(s), OFF_BITS'(off)};
  endfunction

  // mostly a few hot sets and pooled tags, now and then any address at all
  function automatic logic [ADDR_W-1:0] random_addr();
    int pick;
    int s;
    pick = $urandom_range(0, 9);
    if (pick == 0) return {$urandom, $urandom};
    s = (pick < 8) ? $urandom_range(0, 3) : $urandom_range(0, SETS - 1);
    return line_addr(tag_pool[$urandom_range(0, 7)], s, $urandom_range(0, LINE_BYTES - 1));
  endfunction

  // called at a rising edge, returns at the edge where the item is taken
  task automatic issue_access(logic op, logic [ADDR_W-1:0] addr, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= '{operation: op, address: addr};
    do @(negedge clk); while (busy !== 1'b0);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_mode(logic wt, logic wa);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_WRITE_THROUGH;
    cfg_wdata <= CFG_DATA_W'(wt);
    @(posedge clk);
    cfg_idx   <= CFG_WRITE_ALLOCATE;
    cfg_wdata <= CFG_DATA_W'(wa);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [1:0] modes [5];
    int         gap;
    modes = '{2'b01, 2'b11, 2'b00, 2'b10, 2'b01};  // {write-through, write-allocate}
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 8; i++) tag_pool[i] = TAG_BITS'({$urandom, $urandom});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, fills, hits on other offsets, dirty evictions
    issue_access(OP_READ,  '0, 0);
    issue_access(OP_READ,  '1, 1);
    issue_access(OP_WRITE, '0, 0);
    issue_access(OP_WRITE, line_addr('1, SETS - 1, 0), 2);
    issue_access(OP_WRITE, line_addr(TAG_BITS'(1), 0, 5), 0);
    issue_access(OP_WRITE, line_addr(TAG_BITS'(2), 0, 9), 0);
    issue_access(OP_WRITE, line_addr(TAG_BITS'(3), 0, LINE_BYTES - 1), 3);
    issue_access(OP_READ,  line_addr('0, 0, 17), 0);
    issue_access(OP_READ,  line_addr(TAG_BITS'(4), 0, 0), 0);
    issue_access(OP_READ,  line_addr(TAG_BITS'(5), 0, 1), 1);
    issue_access(OP_READ,  line_addr(TAG_BITS'(6), 0, 2), 0);
    issue_access(OP_WRITE, line_addr(TAG_BITS'(5), 0, 7), 0);
    issue_access(OP_READ,  line_addr('1, 0, 0), 0);
    issue_access(OP_READ,  line_addr(TAG_BITS'(2), 0, 0), 0);
    issue_access(OP_WRITE, {$urandom, $urandom}, 4);
    issue_access(OP_READ,  {$urandom, $urandom}, 0);

    foreach (modes[p]) begin
      if (p > 0) begin
        drain();
        set_mode(modes[p][1], modes[p][0]);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(0, 63) == 0) drain();
        if (n % 32 == 0) burst = ($urandom_range(0, 3) == 0);
        gap = burst ? 0 : $urandom_range(0, 16);
        issue_access($urandom_range(0, 1) ? OP_WRITE : OP_READ, random_addr(), gap);
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
